@@ design/iprfr_pkg.sv @@
// Package of the IPv4 forwarding rewrite block: types, codes and constants.
package iprfr_pkg;

    localparam int ROUTE_ENTRIES_DEF   = 256;
    localparam int HEADER_WORDS_DEF    = 37;
    localparam int MAX_FRAME_BYTES_DEF = 65536;

    // Word positions inside the buffered header
    localparam logic [5:0] ETH_WORDS = 6'd7;
    localparam logic [5:0] W_DST0    = 6'd0;
    localparam logic [5:0] W_DST1    = 6'd1;
    localparam logic [5:0] W_DST2    = 6'd2;
    localparam logic [5:0] W_SRC0    = 6'd3;
    localparam logic [5:0] W_SRC1    = 6'd4;
    localparam logic [5:0] W_SRC2    = 6'd5;
    localparam logic [5:0] W_ETYPE   = 6'd6;
    localparam logic [5:0] W_TTL     = 6'd11;
    localparam logic [5:0] W_CSUM    = 6'd12;
    localparam logic [5:0] W_SIP_HI  = 6'd13;
    localparam logic [5:0] W_SIP_LO  = 6'd14;
    localparam logic [5:0] W_DIP_HI  = 6'd15;
    localparam logic [5:0] W_DIP_LO  = 6'd16;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    localparam logic CFG_OWN_MAC     = 1'b0;
    localparam logic CFG_ROUTE_COUNT = 1'b1;

    typedef enum logic [1:0] {
        M_COLLECT = 2'd0,
        M_PASS    = 2'd1,
        M_DISCARD = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SEARCH = 2'd1,
        S_HRD    = 2'd2,
        S_HWR    = 2'd3
    } t_state;

    typedef struct packed {
        logic        emit;
        logic [15:0] word;
        logic [1:0]  bytes;
        logic        last;
        logic        cut;
    } t_put;

endpackage

@@ design/iprfr_in_if.sv @@
// Input channel: route loads and frame words.
interface iprfr_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  route_index;
    logic [31:0] route_src_ip;
    logic [31:0] route_dst_ip;
    logic [47:0] route_next_mac;
    logic [15:0] frame_word;
    logic [1:0]  frame_bytes;
    logic        frame_last;

    modport source (output valid, command, route_index, route_src_ip, route_dst_ip,
                    route_next_mac, frame_word, frame_bytes, frame_last, input ready);
    modport sink (input valid, command, route_index, route_src_ip, route_dst_ip,
                  route_next_mac, frame_word, frame_bytes, frame_last, output ready);
endinterface

@@ design/iprfr_out_if.sv @@
// Output channel: forwarded frame words.
interface iprfr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_word;
    logic [1:0]  out_bytes;
    logic        out_last;

    modport source (output valid, out_word, out_bytes, out_last, input ready);
    modport sink (input valid, out_word, out_bytes, out_last, output ready);
endinterface

@@ design/iprfr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module iprfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ design/ip_route_forward_rewrite.sv @@
// Top level of the IPv4 forwarding rewrite block.
// Route entries and frame words share one input channel. Header words are
// taken one per cycle while the output register is free and are written to
// the header RAM. When the header is complete the block searches the route
// RAMs, one entry per cycle, from entry 0 up to route_count-1 with
// route_count capped at ROUTE_ENTRIES; then each header word is read from
// the RAM and sent out, waiting while the output register is busy. After
// that each payload word is passed on while the output register is free.
// Source/destination IP and the checksum sum are gathered as words
// arrive; the first matching entry wins. Runt, bad-IHL and unrouted
// frames produce no output. No clearing pass is needed.
module ip_route_forward_rewrite #(
    parameter int ROUTE_ENTRIES   = iprfr_pkg::ROUTE_ENTRIES_DEF,
    parameter int HEADER_WORDS    = iprfr_pkg::HEADER_WORDS_DEF,
    parameter int MAX_FRAME_BYTES = iprfr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iprfr_in_if.sink    i_in,
    iprfr_out_if.source o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    import iprfr_pkg::*;

    localparam int AW  = ROUTE_ENTRIES > 1 ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int CW  = $clog2(ROUTE_ENTRIES + 1);
    localparam int HAW = HEADER_WORDS > 1 ? $clog2(HEADER_WORDS) : 1;
    localparam logic [16:0] MAXB = 17'(MAX_FRAME_BYTES);

    // Registers
    t_state       r_state, n_state;
    t_mode        r_mode, n_mode;
    logic [14:0]  r_pos, n_pos;
    logic [5:0]   r_need, n_need;
    logic [20:0]  r_sum, n_sum;
    logic         r_last, n_last;
    logic [CW-1:0] r_sidx, n_sidx;
    logic         r_cvalid, n_cvalid;
    logic [5:0]   r_hidx, n_hidx;
    logic         r_ov, n_ov;
    logic [15:0]  r_ow, n_ow;
    logic [1:0]   r_ob, n_ob;
    logic         r_ol, n_ol;
    logic [31:0]  r_sip, n_sip;
    logic [31:0]  r_dip, n_dip;
    logic [47:0]  r_mac, n_mac;
    logic [47:0]  r_own_mac;
    logic [8:0]   r_route_count;

    // Memory ports
    logic            rt_we;
    logic [AW-1:0]   rt_waddr, rt_raddr;
    logic [31:0]     rt_src_q, rt_dst_q;
    logic [47:0]     rt_mac_q;
    logic            hs_we;
    logic [HAW-1:0]  hs_waddr;
    logic [15:0]     hs_wdata, hs_q;

    logic            out_free, accept, n_one;
    logic [CW-1:0]   lim;
    logic [15:0]     hword;
    logic [16:0]     s1;
    logic [16:0]     s2;
    logic [5:0]      need;
    logic [5:0]      need_eff;
    logic [14:0]     np;
    t_put            pw;

    // Apply the frame size cut to one outgoing word
    function automatic t_put put_word(input logic [14:0] pos, input logic [15:0] w,
                                      input logic [1:0] n, input logic last);
        t_put        p;
        logic [16:0] off;
        off     = {1'b0, pos, 1'b0};
        p.emit  = 1'b1;
        p.word  = w;
        p.bytes = n;
        p.last  = last;
        p.cut   = 1'b0;
        if (off >= MAXB) begin
            p.emit = 1'b0;
            p.cut  = 1'b1;
        end else if (off + {15'd0, n} >= MAXB) begin
            p.bytes = 2'(MAXB - off);
            p.last  = 1'b1;
            p.cut   = 1'b1;
        end
        if (p.bytes == 2'd1) begin
            p.word = {p.word[15:8], 8'h00};
        end
        return p;
    endfunction

    iprfr_ram #(.WIDTH(32), .DEPTH(ROUTE_ENTRIES)) u_src_ram (
        .i_clk(i_clk), .i_we(rt_we), .i_waddr(rt_waddr), .i_wdata(i_in.route_src_ip),
        .i_raddr(rt_raddr), .o_rdata(rt_src_q));
    iprfr_ram #(.WIDTH(32), .DEPTH(ROUTE_ENTRIES)) u_dst_ram (
        .i_clk(i_clk), .i_we(rt_we), .i_waddr(rt_waddr), .i_wdata(i_in.route_dst_ip),
        .i_raddr(rt_raddr), .o_rdata(rt_dst_q));
    iprfr_ram #(.WIDTH(48), .DEPTH(ROUTE_ENTRIES)) u_mac_ram (
        .i_clk(i_clk), .i_we(rt_we), .i_waddr(rt_waddr), .i_wdata(i_in.route_next_mac),
        .i_raddr(rt_raddr), .o_rdata(rt_mac_q));
    iprfr_ram #(.WIDTH(16), .DEPTH(HEADER_WORDS)) u_hdr_ram (
        .i_clk(i_clk), .i_we(hs_we), .i_waddr(hs_waddr), .i_wdata(hs_wdata),
        .i_raddr(HAW'(r_hidx)), .o_rdata(hs_q));

    assign out_free     = !r_ov || o_out.ready;
    assign i_in.ready   = (r_state == S_IDLE) && out_free;
    assign accept       = i_in.valid && i_in.ready;
    assign o_out.valid     = r_ov;
    assign o_out.out_word  = r_ow;
    assign o_out.out_bytes = r_ob;
    assign o_out.out_last  = r_ol;

    assign lim = (int'(r_route_count) > ROUTE_ENTRIES) ? CW'(ROUTE_ENTRIES)
                                                        : CW'(r_route_count);
    assign rt_raddr = r_sidx[AW-1:0];
    assign rt_waddr = AW'(i_in.route_index);
    assign hs_waddr = HAW'(r_pos);

    // Fold the ones' complement sum
    assign s1 = {12'd0, r_sum[20:16]} + {1'b0, r_sum[15:0]};
    assign s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};

    // Pick the outgoing header word
    always_comb begin
        case (r_hidx)
            W_DST0:  hword = r_mac[47:32];
            W_DST1:  hword = r_mac[31:16];
            W_DST2:  hword = r_mac[15:0];
            W_SRC0:  hword = r_own_mac[47:32];
            W_SRC1:  hword = r_own_mac[31:16];
            W_SRC2:  hword = r_own_mac[15:0];
            W_ETYPE: hword = ETYPE_IPV4;
            W_CSUM:  hword = ~s2[15:0];
            default: hword = hs_q;
        endcase
    end

    assign n_one    = (i_in.frame_bytes == 2'd1) && i_in.frame_last;
    assign np       = r_pos + 15'd1;
    assign need     = ETH_WORDS + {1'b0, i_in.frame_word[11:8], 1'b0};
    assign need_eff = (np == 15'(8)) ? need : r_need;

    // Next state and outputs
    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_need   = r_need;
        n_sum    = r_sum;
        n_last   = r_last;
        n_sidx   = r_sidx;
        n_cvalid = r_cvalid;
        n_hidx   = r_hidx;
        n_ov     = o_out.ready ? 1'b0 : r_ov;
        n_ow     = r_ow;
        n_ob     = r_ob;
        n_ol     = r_ol;
        n_sip    = r_sip;
        n_dip    = r_dip;
        n_mac    = r_mac;
        rt_we    = 1'b0;
        hs_we    = 1'b0;
        hs_wdata = i_in.frame_word;
        pw       = put_word(r_pos, i_in.frame_word, n_one ? 2'd1 : 2'd2, i_in.frame_last);
        case (r_state)
            S_IDLE: begin
                if (accept && i_in.command == CMD_LOAD) begin
                    rt_we = int'(i_in.route_index) < ROUTE_ENTRIES;
                end else if (accept && r_mode == M_PASS) begin
                    // pass payload
                    if (pw.emit) begin
                        n_ov = 1'b1;
                        n_ow = pw.word;
                        n_ob = pw.bytes;
                        n_ol = pw.last;
                    end
                    if (r_pos < 15'h7FFF) begin
                        n_pos = np;
                    end
                    if (i_in.frame_last) begin
                        n_pos = '0; n_need = '0; n_sum = '0; n_mode = M_COLLECT;
                    end else if (pw.cut) begin
                        n_mode = M_DISCARD;
                    end
                end else if (accept && r_mode == M_COLLECT) begin
                    // collect header
                    if (n_one || r_pos >= 15'(HEADER_WORDS)) begin
                        n_pos = '0; n_need = '0; n_sum = '0; n_mode = M_COLLECT;
                    end else begin
                        hs_we = 1'b1;
                        if (r_pos == 15'(W_TTL)) begin
                            hs_wdata = {i_in.frame_word[15:8] - 8'd1, i_in.frame_word[7:0]};
                        end
                        if (r_pos >= 15'(ETH_WORDS) && r_pos != 15'(W_CSUM)) begin
                            n_sum = r_sum + {5'd0, hs_wdata};
                        end
                        if (r_pos == 15'(W_SIP_HI)) n_sip[31:16] = i_in.frame_word;
                        if (r_pos == 15'(W_SIP_LO)) n_sip[15:0]  = i_in.frame_word;
                        if (r_pos == 15'(W_DIP_HI)) n_dip[31:16] = i_in.frame_word;
                        if (r_pos == 15'(W_DIP_LO)) n_dip[15:0]  = i_in.frame_word;
                        n_pos = np;
                        if (np == 15'(8) && (i_in.frame_word[11:8] < 4'd5 ||
                                             need > 6'(HEADER_WORDS))) begin
                            if (i_in.frame_last) begin
                                n_pos = '0; n_need = '0; n_sum = '0; n_mode = M_COLLECT;
                            end else begin
                                n_mode = M_DISCARD;
                            end
                        end else begin
                            n_need = need_eff;
                            if (need_eff == 6'd0 || np < 15'(need_eff)) begin
                                if (i_in.frame_last) begin
                                    n_pos = '0; n_need = '0; n_sum = '0;
                                    n_mode = M_COLLECT;
                                end
                            end else begin
                                n_last   = i_in.frame_last;
                                n_sidx   = '0;
                                n_cvalid = 1'b0;
                                n_state  = S_SEARCH;
                            end
                        end
                    end
                end else if (accept) begin
                    // discard to end of frame
                    if (i_in.frame_last) begin
                        n_pos = '0; n_need = '0; n_sum = '0; n_mode = M_COLLECT;
                    end
                end
            end
            S_SEARCH: begin
                // issue one entry per cycle, compare the previous read
                if (r_sidx < lim) begin
                    n_sidx   = r_sidx + CW'(1);
                    n_cvalid = 1'b1;
                end else begin
                    n_cvalid = 1'b0;
                end
                if (r_cvalid && rt_src_q == r_sip && rt_dst_q == r_dip) begin
                    n_mac   = rt_mac_q;
                    n_hidx  = '0;
                    n_state = S_HRD;
                end else if (!r_cvalid && !(r_sidx < lim)) begin
                    n_state = S_IDLE;
                    if (r_last) begin
                        n_pos = '0; n_need = '0; n_sum = '0; n_mode = M_COLLECT;
                    end else begin
                        n_mode = M_DISCARD;
                    end
                end
            end
            S_HRD: begin
                n_state = S_HWR;
            end
            S_HWR: begin
                // send one header word
                pw = put_word({9'd0, r_hidx}, hword, 2'd2,
                              r_last && (r_hidx + 6'd1 == r_need));
                if (out_free) begin
                    if (pw.emit) begin
                        n_ov = 1'b1;
                        n_ow = pw.word;
                        n_ob = pw.bytes;
                        n_ol = pw.last;
                    end
                    n_hidx = r_hidx + 6'd1;
                    if (pw.cut || r_hidx + 6'd1 == r_need) begin
                        n_state = S_IDLE;
                        n_pos   = {9'd0, r_need};
                        if (r_last) begin
                            n_pos = '0; n_need = '0; n_sum = '0; n_mode = M_COLLECT;
                        end else begin
                            n_mode = pw.cut ? M_DISCARD : M_PASS;
                        end
                    end else begin
                        n_state = S_HRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_mode        <= M_COLLECT;
            r_pos         <= '0;
            r_need        <= '0;
            r_sum         <= '0;
            r_cvalid      <= 1'b0;
            r_ov          <= 1'b0;
            r_own_mac     <= '0;
            r_route_count <= '0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_need   <= n_need;
            r_sum    <= n_sum;
            r_cvalid <= n_cvalid;
            r_ov     <= n_ov;
            if (i_cfg_we && i_cfg_index == CFG_OWN_MAC) begin
                r_own_mac <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_ROUTE_COUNT) begin
                r_route_count <= i_cfg_data[8:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_sidx <= n_sidx;
        r_hidx <= n_hidx;
        r_ow   <= n_ow;
        r_ob   <= n_ob;
        r_ol   <= n_ol;
        r_sip  <= n_sip;
        r_dip  <= n_dip;
        r_mac  <= n_mac;
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> r_state == S_IDLE)
        else $error("input ready outside idle");
    a_hwr_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_HWR |-> $past(r_state) == S_HRD || $past(r_state) == S_HWR)
        else $error("header write without read");
    a_pass_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == M_PASS |-> r_need != 6'd0)
        else $error("pass mode without header length");
    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SEARCH |-> r_sidx <= lim)
        else $error("search index past limit");
`endif
endmodule

@@ tb/tb_frame_pkg.sv @@
// Stimulus and expected-output word types used by the forwarding testbench.
package tb_frame_pkg;

    typedef struct packed {
        logic        command;
        logic [7:0]  route_index;
        logic [31:0] route_src_ip;
        logic [31:0] route_dst_ip;
        logic [47:0] route_next_mac;
        logic [15:0] frame_word;
        logic [1:0]  frame_bytes;
        logic        frame_last;
    } t_in_word;

    typedef struct packed {
        logic [15:0] word;
        logic [1:0]  bytes;
        logic        last;
    } t_out_word;

endpackage

@@ tb/tb.sv @@
// Testbench of the IPv4 forwarding rewrite block: directed and random routes and frames, checked word by word.
module tb;
    import iprfr_pkg::*;
    import tb_frame_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 600;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_index;
    logic [47:0] i_cfg_data;

    iprfr_in_if  in_ch();
    iprfr_out_if out_ch();

    ip_route_forward_rewrite dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Forwarding model state
    logic [47:0] mdl_own_mac;
    logic [8:0]  mdl_route_count;
    logic [31:0] mdl_src_tab [256];
    logic [31:0] mdl_dst_tab [256];
    logic [47:0] mdl_mac_tab [256];
    logic [15:0] mdl_hdr [37];
    int          mdl_pos;
    int          mdl_need;
    t_mode       mdl_mode;

    t_in_word  pending_words [$];
    t_out_word expected_words [$];
    int        error_count;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        idle_cycles;
    bit        stim_done;
    bit        loaded [256];

    // Clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    function automatic void frame_restart();
        mdl_pos  = 0;
        mdl_need = 0;
        mdl_mode = M_COLLECT;
    endfunction

    // Push one output word, applying the frame size cut; return 1 when cut
    function automatic bit push_word(input int pos, input logic [15:0] w, input int n,
                                     input bit last);
        int off;
        bit cut;
        t_out_word o;
        off = pos * 2;
        cut = 1'b0;
        if (off >= MAX_FRAME_BYTES_DEF) return 1'b1;
        if (off + n >= MAX_FRAME_BYTES_DEF) begin
            n = MAX_FRAME_BYTES_DEF - off;
            last = 1'b1;
            cut = 1'b1;
        end
        if (n == 1) w = w & 16'hFF00;
        o.word = w;
        o.bytes = 2'(n);
        o.last = last;
        expected_words.push_back(o);
        return cut;
    endfunction

    // Predict the forwarded words caused by one accepted input word
    function automatic void forward_predict(input t_in_word iw);
        bit last, cut, found;
        int n, ihl, lim, hit;
        logic [31:0] sip, dip, sum;
        logic [7:0] ttl;
        last = iw.frame_last;
        n = (iw.frame_bytes == 2'd1 && last) ? 1 : 2;
        if (iw.command == CMD_LOAD) begin
            mdl_src_tab[iw.route_index] = iw.route_src_ip;
            mdl_dst_tab[iw.route_index] = iw.route_dst_ip;
            mdl_mac_tab[iw.route_index] = iw.route_next_mac;
            return;
        end
        if (mdl_mode == M_PASS) begin
            cut = push_word(mdl_pos, iw.frame_word, n, last);
            if (mdl_pos < 32'h7FFF) mdl_pos++;
            if (last) frame_restart();
            else if (cut) mdl_mode = M_DISCARD;
            return;
        end
        if (mdl_mode != M_COLLECT) begin
            if (last) frame_restart();
            return;
        end
        if (n == 1 || mdl_pos >= HEADER_WORDS_DEF) begin
            frame_restart();
            return;
        end
        mdl_hdr[mdl_pos] = iw.frame_word;
        mdl_pos++;
        if (mdl_pos == 8) begin
            ihl = iw.frame_word[11:8];
            if (ihl < 5 || 7 + ihl * 2 > HEADER_WORDS_DEF) begin
                if (last) frame_restart();
                else mdl_mode = M_DISCARD;
                return;
            end
            mdl_need = 7 + ihl * 2;
        end
        if (mdl_need == 0 || mdl_pos < mdl_need) begin
            if (last) frame_restart();
            return;
        end
        sip = {mdl_hdr[13], mdl_hdr[14]};
        dip = {mdl_hdr[15], mdl_hdr[16]};
        lim = (mdl_route_count > 256) ? 256 : int'(mdl_route_count);
        found = 1'b0;
        hit = 0;
        for (int i = 0; i < lim && !found; i++) begin
            if (mdl_src_tab[i] == sip && mdl_dst_tab[i] == dip) begin
                found = 1'b1;
                hit = i;
            end
        end
        if (!found) begin
            if (last) frame_restart();
            else mdl_mode = M_DISCARD;
            return;
        end
        mdl_hdr[0] = mdl_mac_tab[hit][47:32];
        mdl_hdr[1] = mdl_mac_tab[hit][31:16];
        mdl_hdr[2] = mdl_mac_tab[hit][15:0];
        mdl_hdr[3] = mdl_own_mac[47:32];
        mdl_hdr[4] = mdl_own_mac[31:16];
        mdl_hdr[5] = mdl_own_mac[15:0];
        mdl_hdr[6] = ETYPE_IPV4;
        ttl = mdl_hdr[11][15:8] - 8'd1;
        mdl_hdr[11] = {ttl, mdl_hdr[11][7:0]};
        mdl_hdr[12] = 16'h0;
        sum = 0;
        for (int i = 7; i < mdl_need; i++) sum += mdl_hdr[i];
        sum = (sum >> 16) + (sum & 32'hFFFF);
        sum += sum >> 16;
        mdl_hdr[12] = ~sum[15:0];
        cut = 1'b0;
        for (int i = 0; i < mdl_need && !cut; i++)
            cut = push_word(i, mdl_hdr[i], 2, last && i + 1 == mdl_need);
        mdl_pos = mdl_need;
        if (last) frame_restart();
        else mdl_mode = cut ? M_DISCARD : M_PASS;
    endfunction

    // Driver: hold the word until accepted, idle at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_ch.ready) begin
            in_ch.valid <= 1'b1;
        end else begin
            if (in_ch.valid) begin
                forward_predict({in_ch.command, in_ch.route_index, in_ch.route_src_ip,
                                 in_ch.route_dst_ip, in_ch.route_next_mac, in_ch.frame_word,
                                 in_ch.frame_bytes, in_ch.frame_last});
                void'(pending_words.pop_front());
            end
            // the front of the queue is the next word to drive
            if (pending_words.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                t_in_word nw;
                nw = pending_words[0];
                in_ch.valid          <= 1'b1;
                in_ch.command        <= nw.command;
                in_ch.route_index    <= nw.route_index;
                in_ch.route_src_ip   <= nw.route_src_ip;
                in_ch.route_dst_ip   <= nw.route_dst_ip;
                in_ch.route_next_mac <= nw.route_next_mac;
                in_ch.frame_word     <= nw.frame_word;
                in_ch.frame_bytes    <= nw.frame_bytes;
                in_ch.frame_last     <= nw.frame_last;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted output word, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            idle_cycles  <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", out_ch.out_word, 16'h0);
                end else begin
                    t_out_word e;
                    e = expected_words.pop_front();
                    if (out_ch.out_word !== e.word)
                        report_mismatch("word", out_ch.out_word, e.word);
                    if (out_ch.out_bytes !== e.bytes)
                        report_mismatch("bytes", 16'(out_ch.out_bytes), 16'(e.bytes));
                    if (out_ch.out_last !== e.last)
                        report_mismatch("last", 16'(out_ch.out_last), 16'(e.last));
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else if (!stim_done || expected_words.size() != 0)
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_word(input logic [15:0] w, input bit last, input logic [1:0] nb);
        t_in_word iw;
        iw = t_in_word'($urandom());
        iw.route_src_ip = $urandom();
        iw.command = CMD_FRAME;
        iw.frame_word = w;
        iw.frame_last = last;
        iw.frame_bytes = nb;
        pending_words.push_back(iw);
    endtask

    task automatic add_route(input int idx, input logic [31:0] s, input logic [31:0] d);
        t_in_word iw;
        iw = t_in_word'($urandom());
        iw.command = CMD_LOAD;
        iw.route_index = 8'(idx);
        iw.route_src_ip = s;
        iw.route_dst_ip = d;
        iw.route_next_mac = {$urandom(), $urandom()};
        iw.frame_bytes = 2'($urandom());
        iw.frame_last = $urandom();
        pending_words.push_back(iw);
        loaded[idx] = 1'b1;
    endtask

    // Queue one frame; payload words after an IHL-sized header of at least 17 words, cut short at runt_at
    task automatic add_frame(input logic [31:0] s, input logic [31:0] d, input int ihl,
                             input int payload, input int runt_at, input bit odd_end);
        int hw, total;
        logic [15:0] w;
        hw = 7 + ihl * 2;
        if (hw < 17) hw = 17;
        total = hw + payload;
        for (int i = 0; i < total; i++) begin
            w = $urandom();
            if (i == 7) w[11:8] = 4'(ihl);
            if (i == 13) w = s[31:16];
            if (i == 14) w = s[15:0];
            if (i == 15) w = d[31:16];
            if (i == 16) w = d[15:0];
            if (i == runt_at) begin
                add_word(w, 1'b1, odd_end ? 2'd1 : 2'($urandom()));
                return;
            end
            if (i == total - 1)
                add_word(w, 1'b1, odd_end ? 2'd1 : 2'd2);
            else
                add_word(w, 1'b0, ($urandom_range(3) == 0) ? 2'($urandom()) : 2'd2);
        end
    endtask

    task automatic wait_drain();
        while (pending_words.size() != 0 || in_ch.valid || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [47:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == CFG_OWN_MAC) mdl_own_mac = val;
        else mdl_route_count = val[8:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Pick a frame address pair: mostly a loaded route, sometimes a miss
    task automatic random_frame();
        int idx, ihl, pl;
        logic [31:0] s, d;
        idx = $urandom_range(15);
        if (loaded[idx] && $urandom_range(9) < 8) begin
            s = mdl_src_tab[idx];
            d = mdl_dst_tab[idx];
        end else begin
            s = $urandom();
            d = $urandom();
        end
        ihl = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(5, 7);
        pl = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 12);
        add_frame(s, d, ihl, pl, ($urandom_range(14) == 0) ? $urandom_range(16) : -1,
                  $urandom_range(1) == 1);
    endtask

    initial begin
        int phase_pct [4][2];
        logic [31:0] a, b;
        phase_pct = '{'{0, 0}, '{79, 0}, '{0, 79}, '{21, 21}};
        error_count = 0;
        stim_done = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_OWN_MAC;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_LOAD;
        in_ch.route_index = '0;
        in_ch.route_src_ip = '0;
        in_ch.route_dst_ip = '0;
        in_ch.route_next_mac = '0;
        in_ch.frame_word = '0;
        in_ch.frame_bytes = 2'd2;
        in_ch.frame_last = 1'b0;
        out_ch.ready = 1'b0;
        mdl_own_mac = '0;
        mdl_route_count = '0;
        frame_restart();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme addresses and MACs, bad IHL, runt, no route
        write_cfg(CFG_OWN_MAC, 48'hFFFF_FFFF_FFFF);
        write_cfg(CFG_ROUTE_COUNT, 9'd16);
        add_route(0, 32'h0, 32'hFFFF_FFFF);
        add_route(15, 32'hFFFF_FFFF, 32'h0);
        add_route(255, 32'h1234_5678, 32'h9ABC_DEF0);
        for (int i = 1; i < 15; i++) add_route(i, $urandom(), $urandom());
        add_frame(32'h0, 32'hFFFF_FFFF, 5, 2, -1, 1'b1);
        add_frame(32'hFFFF_FFFF, 32'h0, 15, 1, -1, 1'b0);
        add_frame(32'h1, 32'h2, 5, 1, -1, 1'b0);
        add_frame(32'h0, 32'hFFFF_FFFF, 4, 2, -1, 1'b0);
        add_frame(32'h0, 32'hFFFF_FFFF, 5, 0, 9, 1'b0);
        wait_drain();

        write_cfg(CFG_ROUTE_COUNT, 9'd0);
        add_frame(32'h0, 32'hFFFF_FFFF, 5, 1, -1, 1'b0);
        wait_drain();

        // Fill the rest of the table before any full-length search
        for (int i = 16; i < 255; i++) add_route(i, $urandom(), $urandom());
        wait_drain();
        write_cfg(CFG_OWN_MAC, 48'h0);
        write_cfg(CFG_ROUTE_COUNT, 9'd256);
        add_frame(32'h1234_5678, 32'h9ABC_DEF0, 6, 3, -1, 1'b1);
        wait_drain();

        // Random phases across idle settings and register values
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = phase_pct[ph][0];
            recv_stall_pct = phase_pct[ph][1];
            write_cfg(CFG_OWN_MAC, {$urandom(), $urandom()});
            write_cfg(CFG_ROUTE_COUNT, (ph == 3) ? 9'd8 : (ph == 1) ? 9'd511 :
                                       9'(256 - $urandom_range(2)));
            if ($urandom_range(3) == 0) begin
                a = $urandom();
                b = $urandom();
                add_route($urandom_range(15), a, b);
            end
            random_frame();
            wait_drain();
        end
        stim_done = 1'b1;
        if (error_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
